### design/pidc_pkg.sv
package pidc_pkg;

  // Field and datapath widths
  localparam int DATA_W    = 32;
  localparam int LIMIT_W   = 31;
  localparam int ACC_W     = 48;
  localparam int CFG_IDX_W = 3;
  localparam int FRAC_W    = 16;

  // Serial multiplier: ACC_W-bit signed multiplicand, DATA_W-bit signed multiplier
  localparam int MUL_A_W   = ACC_W;
  localparam int MUL_B_W   = DATA_W;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W = $clog2(MUL_B_W);

  // Serial divider: (|diff| << FRAC_W) / period
  localparam int DVD_W     = DATA_W + 1 + FRAC_W;
  localparam int DIV_CNT_W = $clog2(DVD_W);

  // Sum of the three gain terms
  localparam int TERM_W    = PROD_W - FRAC_W;
  localparam int SUM_W     = TERM_W + 2;

  localparam logic [DATA_W-1:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] S32_MIN = 32'h8000_0000;
  localparam logic [ACC_W-1:0]  ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0]  ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // Commands
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // Register map
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_EN   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DRIVE  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_THR   = 3'd7;

  // Register reset values
  localparam logic [DATA_W-1:0]  PERIOD_RST    = 32'h0001_0000;
  localparam logic [LIMIT_W-1:0] MAX_DRIVE_RST = {LIMIT_W{1'b1}};

  // Status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } pidc_unit_st_t;

endpackage

### design/pidc_in_if.sv
interface pidc_in_if;
  import pidc_pkg::*;

  logic              valid;
  logic              ready;
  logic              cmd;
  logic [DATA_W-1:0] measured_value;

  modport source (output valid, output cmd, output measured_value, input ready);
  modport sink   (input valid, input cmd, input measured_value, output ready);
endinterface

### design/pidc_out_if.sv
interface pidc_out_if;
  import pidc_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] drive_out;
  logic              goal_reached;
  logic              clamped;

  modport source (output valid, output drive_out, output goal_reached, output clamped,
                  input ready);
  modport sink   (input valid, input drive_out, input goal_reached, input clamped,
                  output ready);
endinterface

### design/pidc_mul.sv
module pidc_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pidc_pkg::MUL_A_W-1:0]  a,
  input  logic [pidc_pkg::MUL_B_W-1:0]  b,
  output logic [pidc_pkg::PROD_W-1:0]   prod,
  output pidc_pkg::pidc_unit_st_t       st
);
  import pidc_pkg::*;

  logic [MUL_A_W-1:0]   mcand;
  logic [MUL_B_W-1:0]   mplier;
  logic [MUL_A_W:0]     phi;
  logic [MUL_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic                 last;
  logic [MUL_A_W:0]     ext;
  logic [MUL_A_W:0]     addend;
  logic [MUL_A_W:0]     tsum;

  // One multiplier bit per cycle, LSB first; the sign bit weighs negative.
  always_comb begin
    last   = (cnt == MUL_CNT_W'(MUL_B_W - 1));
    ext    = {mcand[MUL_A_W-1], mcand};
    addend = '0;
    if (mplier[0]) begin
      addend = last ? (~ext + 1'b1) : ext;
    end
    tsum = phi + addend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && last;
      if (start) begin
        mcand  <= a;
        mplier <= b;
        phi    <= '0;
        cnt    <= '0;
        busy   <= 1'b1;
      end else if (busy) begin
        phi    <= {tsum[MUL_A_W], tsum[MUL_A_W:1]};
        mplier <= {tsum[0], mplier[MUL_B_W-1:1]};
        cnt    <= cnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign prod    = {phi[MUL_A_W-1:0], mplier};
  assign st.busy = busy;
  assign st.done = done;

endmodule

### design/pidc_div.sv
module pidc_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pidc_pkg::DVD_W-1:0]    dividend,
  input  logic [pidc_pkg::DATA_W-1:0]   divisor,
  output logic [pidc_pkg::DVD_W-1:0]    quot,
  output pidc_pkg::pidc_unit_st_t       st
);
  import pidc_pkg::*;

  logic [DVD_W-1:0]     dvd;
  logic [DATA_W-1:0]    dsr;
  logic [DATA_W-1:0]    rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic                 last;
  logic [DATA_W:0]      trial;
  logic [DATA_W:0]      diff;
  logic                 ge;

  // Restoring division, one quotient bit per cycle, MSB first.
  always_comb begin
    last  = (cnt == DIV_CNT_W'(DVD_W - 1));
    trial = {rem, dvd[DVD_W-1]};
    ge    = (trial >= {1'b0, dsr});
    diff  = trial - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && last;
      if (start) begin
        dvd  <= dividend;
        dsr  <= divisor;
        rem  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
        dvd <= {dvd[DVD_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign quot    = dvd;
  assign st.busy = busy;
  assign st.done = done;

endmodule

### design/pid_controller_clamped.sv
// Clamped discrete PID controller, signed Q16.16.
//
// Channels: "sample" carries one item per transfer (cmd, measured_value);
// "result" returns exactly one item per sample item (drive_out, goal_reached,
// clamped). Registers are written through cfg_wen / cfg_index / cfg_data, one
// register per cycle. The user must write them only while the block is idle;
// the block itself does not enforce it.
// A sample item (cmd 0) runs a 49-step bit-serial divide for the derivative,
// then four 32-step bit-serial products on one shared multiplier (integral
// step, integral, proportional and derivative terms), then saturation and the
// limit clamp. A clear item (cmd 1) zeroes the integral and goes straight to
// the output state. One item is in flight at a time.
//
// The next item is taken while a finished result still waits on "result";
// if the receiver stalls, the new item's result holds in a final state until
// the output register frees. Synchronous reset (rst) empties the output,
// zeroes the integral and the stored error, and loads register defaults.
module pid_controller_clamped (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wen,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pidc_pkg::DATA_W-1:0]     cfg_data,
  pidc_in_if.sink                         sample,
  pidc_out_if.source                      result
);
  import pidc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_DIV,
    S_MUL_I,
    S_MUL_G,
    S_MUL_P,
    S_MUL_D,
    S_SAT,
    S_LIM,
    S_OUT
  } state_t;

  // Configuration registers
  logic [DATA_W-1:0]  setpoint;
  logic [DATA_W-1:0]  gain_prop;
  logic [DATA_W-1:0]  gain_integ;
  logic [DATA_W-1:0]  gain_deriv;
  logic [DATA_W-1:0]  sample_period;
  logic               limit_en;
  logic [LIMIT_W-1:0] max_drive;
  logic [DATA_W-1:0]  goal_thr;

  // Loop state and work registers
  state_t             state;
  logic [ACC_W-1:0]   integ;
  logic [DATA_W-1:0]  prev_error;
  logic [DATA_W-1:0]  err;
  logic [DATA_W-1:0]  deriv;
  logic               diff_neg;
  logic [SUM_W-1:0]   sum;
  logic [DATA_W-1:0]  drive;
  logic               clamp;

  // Output register
  logic               res_valid;
  logic [DATA_W-1:0]  res_drive;
  logic               res_goal;
  logic               res_clamp;

  // Serial unit handoff
  logic               mul_start;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  mul_prod;
  pidc_unit_st_t      mul_st;
  logic               div_start;
  logic [DVD_W-1:0]   div_dvd;
  logic [DATA_W-1:0]  div_dsr;
  logic [DVD_W-1:0]   div_quot;
  pidc_unit_st_t      div_st;

  // Combinational helpers
  logic               in_xfer;
  logic               out_free;
  logic [DATA_W:0]    err_wide;
  logic [DATA_W-1:0]  err_sat;
  logic [DATA_W:0]    diff_wide;
  logic [DATA_W:0]    diff_mag;
  logic [DATA_W-1:0]  deriv_sat;
  logic [ACC_W-1:0]   step;
  logic [ACC_W:0]     acc_sum;
  logic [ACC_W-1:0]   integ_next;
  logic [TERM_W-1:0]  term;
  logic [SUM_W-1:0]   term_ext;
  logic               sum_ovf;
  logic [DATA_W:0]    drive_wide;
  logic [DATA_W:0]    lim_pos;
  logic [DATA_W:0]    lim_neg;
  logic               goal_now;

  pidc_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (mul_prod),
    .st    (mul_st)
  );

  pidc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .quot     (div_quot),
    .st       (div_st)
  );

  assign in_xfer  = sample.valid && sample.ready;
  assign out_free = !res_valid || result.ready;

  always_comb begin
    // Error: 33-bit difference saturated to 32 bits
    err_wide = {sample.measured_value[DATA_W-1], sample.measured_value}
             - {setpoint[DATA_W-1], setpoint};
    err_sat  = err_wide[DATA_W-1:0];
    if (err_wide[DATA_W] != err_wide[DATA_W-1]) begin
      err_sat = err_wide[DATA_W] ? S32_MIN : S32_MAX;
    end

    // Error change, as sign and magnitude for the unsigned divider
    diff_wide = {err[DATA_W-1], err} - {prev_error[DATA_W-1], prev_error};
    diff_mag  = diff_wide[DATA_W] ? (~diff_wide + 1'b1) : diff_wide;

    // Derivative: apply the sign and saturate the quotient to 32 bits
    if (diff_neg) begin
      if ((div_quot[DVD_W-1:DATA_W] != '0) ||
          (div_quot[DATA_W-1] && (div_quot[DATA_W-2:0] != '0))) begin
        deriv_sat = S32_MIN;
      end else begin
        deriv_sat = ~div_quot[DATA_W-1:0] + 1'b1;
      end
    end else begin
      deriv_sat = (div_quot[DVD_W-1:DATA_W-1] != '0) ? S32_MAX : div_quot[DATA_W-1:0];
    end

    // Integral step floor(err * period / 2^16) and saturating accumulate
    step       = mul_prod[ACC_W+FRAC_W-1:FRAC_W];
    acc_sum    = {integ[ACC_W-1], integ} + {step[ACC_W-1], step};
    integ_next = acc_sum[ACC_W-1:0];
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
      integ_next = acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
    end

    // Gain term floored to Q16.16
    term     = mul_prod[PROD_W-1:FRAC_W];
    term_ext = {{(SUM_W-TERM_W){term[TERM_W-1]}}, term};

    sum_ovf = (sum[SUM_W-1:DATA_W-1] != {(SUM_W-DATA_W+1){sum[SUM_W-1]}});

    drive_wide = {drive[DATA_W-1], drive};
    lim_pos    = {2'b00, max_drive};
    lim_neg    = ~lim_pos + 1'b1;

    goal_now = ($signed(prev_error) < $signed(goal_thr));
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint      <= '0;
      gain_prop     <= '0;
      gain_integ    <= '0;
      gain_deriv    <= '0;
      sample_period <= PERIOD_RST;
      limit_en      <= 1'b1;
      max_drive     <= MAX_DRIVE_RST;
      goal_thr      <= '0;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_SETPOINT:   setpoint      <= cfg_data;
        REG_GAIN_PROP:  gain_prop     <= cfg_data;
        REG_GAIN_INTEG: gain_integ    <= cfg_data;
        REG_GAIN_DERIV: gain_deriv    <= cfg_data;
        REG_PERIOD:     sample_period <= cfg_data;
        REG_LIMIT_EN:   limit_en      <= cfg_data[0];
        REG_MAX_DRIVE:  max_drive     <= cfg_data[LIMIT_W-1:0];
        REG_GOAL_THR:   goal_thr      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer: state, loop state and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      integ      <= '0;
      prev_error <= '0;
      res_valid  <= 1'b0;
      mul_start  <= 1'b0;
      div_start  <= 1'b0;
    end else begin
      // Launch the divider after the error change forms, and the multiplier
      // as each earlier step finishes
      div_start <= (state == S_DIFF);
      mul_start <= ((state == S_DIV) && div_st.done) ||
                   ((state inside {S_MUL_I, S_MUL_G, S_MUL_P}) && mul_st.done);

      // Drop the result once the receiver takes it, unless a new one loads
      if (res_valid && result.ready && (state != S_OUT)) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (sample.cmd == CMD_CLEAR) begin
              integ <= '0;
              drive <= '0;
              clamp <= 1'b0;
              state <= S_OUT;
            end else begin
              err   <= err_sat;
              state <= S_DIFF;
            end
          end
        end
        S_DIFF: begin
          div_dvd    <= {diff_mag, {FRAC_W{1'b0}}};
          div_dsr    <= (sample_period == '0) ? DATA_W'(1) : sample_period;
          diff_neg   <= diff_wide[DATA_W];
          prev_error <= err;
          state      <= S_DIV;
        end
        S_DIV: begin
          if (div_st.done) begin
            deriv     <= deriv_sat;
            mul_a     <= {{(MUL_A_W-DATA_W){1'b0}}, sample_period};
            mul_b     <= err;
            state     <= S_MUL_I;
          end
        end
        S_MUL_I: begin
          if (mul_st.done) begin
            integ     <= integ_next;
            mul_a     <= integ_next;
            mul_b     <= gain_integ;
            state     <= S_MUL_G;
          end
        end
        S_MUL_G: begin
          if (mul_st.done) begin
            sum       <= term_ext;
            mul_a     <= {{(MUL_A_W-DATA_W){err[DATA_W-1]}}, err};
            mul_b     <= gain_prop;
            state     <= S_MUL_P;
          end
        end
        S_MUL_P: begin
          if (mul_st.done) begin
            sum       <= sum + term_ext;
            mul_a     <= {{(MUL_A_W-DATA_W){deriv[DATA_W-1]}}, deriv};
            mul_b     <= gain_deriv;
            state     <= S_MUL_D;
          end
        end
        S_MUL_D: begin
          if (mul_st.done) begin
            sum   <= sum + term_ext;
            state <= S_SAT;
          end
        end
        S_SAT: begin
          // Saturate the exact sum to 32 bits
          if (sum_ovf) begin
            drive <= sum[SUM_W-1] ? S32_MIN : S32_MAX;
          end else begin
            drive <= sum[DATA_W-1:0];
          end
          clamp <= sum_ovf;
          state <= S_LIM;
        end
        S_LIM: begin
          // Clamp only when strictly outside +/-max_drive
          if (limit_en) begin
            if ($signed(drive_wide) > $signed(lim_pos)) begin
              drive <= lim_pos[DATA_W-1:0];
              clamp <= 1'b1;
            end else if ($signed(drive_wide) < $signed(lim_neg)) begin
              drive <= lim_neg[DATA_W-1:0];
              clamp <= 1'b1;
            end
          end
          state <= S_OUT;
        end
        S_OUT: begin
          // Hold until the output register frees, then load it
          if (out_free) begin
            res_valid <= 1'b1;
            res_drive <= drive;
            res_goal  <= goal_now;
            res_clamp <= clamp;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign sample.ready        = (state == S_IDLE);
  assign result.valid        = res_valid;
  assign result.drive_out    = res_drive;
  assign result.goal_reached = res_goal;
  assign result.clamped      = res_clamp;

`ifndef SYNTHESIS
  // A clear transfer leaves the integral at zero
  a_clear_zeroes: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && sample.cmd == CMD_CLEAR) |=> (integ == '0))
    else $error("integral not cleared after clear item");

  // The divider and the multiplier never run at the same time
  a_units_excl: assert property (@(posedge clk) disable iff (rst)
    !(mul_st.busy && div_st.busy))
    else $error("divider and multiplier busy together");

  // With limiting on, a presented drive stays within +/-max_drive
  a_drive_limited: assert property (@(posedge clk) disable iff (rst)
    (res_valid && limit_en) |->
      ($signed({res_drive[DATA_W-1], res_drive}) <= $signed(lim_pos) &&
       $signed({res_drive[DATA_W-1], res_drive}) >= $signed(lim_neg)))
    else $error("drive outside the limit");
`endif

endmodule
